// ===== hw/rtl/psynth_pkg.sv =====
// Shared types, constants and register map of the plucked-string voice.
package psynth_pkg;

    localparam int MAX_DELAY_DEF = 1024;
    localparam int MAX_NOTE_DEF  = 32768;

    localparam int SAMPLE_W = 16;   // Q1.15 delay entries
    localparam int EXT_W    = 17;   // room for lengths and counts up to 65536

    // register map, index = paddr[3:2]
    localparam logic [1:0] REG_DELAY_LENGTH = 2'd0;
    localparam logic [1:0] REG_NOTE_LENGTH  = 2'd1;
    localparam logic [1:0] REG_DAMPING      = 2'd2;

    localparam logic [10:0] DELAY_LENGTH_RST = 11'd2;
    localparam logic [15:0] NOTE_LENGTH_RST  = 16'd32768;
    localparam logic [15:0] DAMPING_RST      = 16'd65208;
    localparam logic [EXT_W-1:0] MIN_DELAY   = 17'd2;

    // action codes on s_tuser
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    localparam logic signed [23:0] OUT_SCALE  = 24'sd120;
    localparam logic signed [23:0] TRUNC_BIAS = 24'sd32767;

    typedef struct packed {
        logic [10:0] delay_length;
        logic [15:0] note_length;
        logic [15:0] damping;
    } cfg_t;

    // one request handed from the issue stage to the update stage
    typedef struct packed {
        logic valid;   // update stage has work to do
        logic step;    // produce a sample, else load
        logic wr;      // load hits an existing entry
        logic last;    // final sample of the note
    } op_t;

endpackage

// ===== hw/rtl/psynth_regs.sv =====
// APB configuration registers of the plucked-string voice.
module psynth_regs
    import psynth_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delay_length <= DELAY_LENGTH_RST;
            cfg_reg.note_length  <= NOTE_LENGTH_RST;
            cfg_reg.damping      <= DAMPING_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_DELAY_LENGTH: cfg_reg.delay_length <= pwdata[10:0];
                REG_NOTE_LENGTH:  cfg_reg.note_length  <= pwdata[15:0];
                REG_DAMPING:      cfg_reg.damping      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_DELAY_LENGTH: prdata = 32'(cfg_reg.delay_length);
            REG_NOTE_LENGTH:  prdata = 32'(cfg_reg.note_length);
            REG_DAMPING:      prdata = 32'(cfg_reg.damping);
            default:          prdata = 32'd0;
        endcase
    end

endmodule

// ===== hw/rtl/psynth_issue.sv =====
// Issue stage: read position and sample count, address and request for each item.
module psynth_issue
    import psynth_pkg::*;
#(
    parameter int MAX_DELAY = MAX_DELAY_DEF,
    parameter int MAX_NOTE  = MAX_NOTE_DEF,
    localparam int AW = $clog2(MAX_DELAY),
    localparam int CW = $clog2(MAX_NOTE + 1)
)(
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                accept,
    input  logic                action,
    input  logic [9:0]          entry_index,
    input  logic signed [7:0]   excitation,
    output op_t                 op,
    output logic [AW-1:0]       addr,
    output logic [SAMPLE_W-1:0] load_data
);

    logic [AW-1:0]    pos_reg, pos_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [EXT_W-1:0] count_ext, pos_ext, idx_ext, len, notes, dl_ext, nl_ext;
    logic             is_step, live, idx_ok;

    assign is_step = (action == ACT_STEP);
    assign count_ext = EXT_W'(count_reg);
    assign pos_ext   = EXT_W'(pos_reg);
    assign idx_ext   = EXT_W'(entry_index);
    assign dl_ext    = EXT_W'(cfg.delay_length);
    assign nl_ext    = EXT_W'(cfg.note_length);

    always_comb begin
        if (dl_ext < MIN_DELAY)
            len = MIN_DELAY;
        else if (dl_ext > EXT_W'(MAX_DELAY))
            len = EXT_W'(MAX_DELAY);
        else
            len = dl_ext;
        notes = (nl_ext > EXT_W'(MAX_NOTE)) ? EXT_W'(MAX_NOTE) : nl_ext;
    end

    assign live   = count_ext < notes;
    assign idx_ok = idx_ext < EXT_W'(MAX_DELAY);

    assign op.valid  = accept && (!is_step || live);
    assign op.step   = is_step;
    assign op.wr     = !is_step && idx_ok;
    assign op.last   = (count_ext + EXT_W'(1)) == notes;
    assign addr      = is_step ? pos_reg : idx_ext[AW-1:0];
    assign load_data = {excitation, 8'd0};

    always_comb begin
        pos_next   = pos_reg;
        count_next = count_reg;
        if (accept) begin
            if (!is_step) begin
                pos_next   = '0;
                count_next = '0;
            end else if (live) begin
                // a position left past a shortened line is still used, then wraps
                pos_next   = (pos_ext + EXT_W'(1) >= len) ? '0 : pos_reg + AW'(1);
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            count_reg <= '0;
        end else begin
            pos_reg   <= pos_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/psynth_loop.sv =====
// Delay-line memory, damped-average update stage and output register.
module psynth_loop
    import psynth_pkg::*;
#(
    parameter int MAX_DELAY = MAX_DELAY_DEF,
    localparam int AW = $clog2(MAX_DELAY)
)(
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  op_t                 op,
    input  logic [AW-1:0]       addr,
    input  logic [SAMPLE_W-1:0] load_data,
    output logic                take,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast
);

    logic [SAMPLE_W-1:0] mem [MAX_DELAY];
    logic [SAMPLE_W-1:0] rd_reg, fwd_data_reg, cur, prev_reg, wr_data, nv;
    logic                fwd_reg;

    op_t                 s1_reg;
    logic [AW-1:0]       s1_addr_reg;
    logic [SAMPLE_W-1:0] s1_ldata_reg;

    logic                m_valid_reg, m_last_reg;
    logic [7:0]          m_data_reg;

    logic                out_free, s1_adv, wr_now;
    logic signed [16:0]  sum;
    logic signed [33:0]  prod;
    logic signed [23:0]  mul120, biased, shifted;

    assign out_free = !m_valid_reg || m_tready;
    assign s1_adv   = s1_reg.valid && (!s1_reg.step || out_free);
    assign take     = !s1_reg.valid || s1_adv;
    assign wr_now   = s1_adv && (s1_reg.step || s1_reg.wr);

    // entry written at the same edge as it is read comes from the bypass
    assign cur = fwd_reg ? fwd_data_reg : rd_reg;

    assign sum  = $signed({cur[15], cur}) + $signed({prev_reg[15], prev_reg});
    assign prod = sum * $signed({1'b0, cfg.damping});
    assign nv   = prod[32:17];

    assign mul120  = $signed(cur) * OUT_SCALE;
    assign biased  = mul120 + (mul120[23] ? TRUNC_BIAS : 24'sd0);
    assign shifted = biased >>> 15;

    assign wr_data = s1_reg.step ? nv : s1_ldata_reg;

    always_ff @(posedge aclk) begin
        if (wr_now)
            mem[s1_addr_reg] <= wr_data;
        if (take)
            rd_reg <= mem[addr];
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            fwd_data_reg <= wr_data;
            s1_addr_reg  <= addr;
            s1_ldata_reg <= load_data;
        end
        if (s1_adv && s1_reg.step) begin
            m_data_reg <= shifted[7:0];
            m_last_reg <= s1_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg      <= '0;
            fwd_reg     <= 1'b0;
            prev_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                s1_reg  <= op;
                fwd_reg <= wr_now && (s1_addr_reg == addr);
            end
            if (s1_adv)
                prev_reg <= s1_reg.step ? nv : '0;
            if (s1_adv && s1_reg.step)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // back-to-back steps never touch the same entry
    a_step_addr_differs: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_adv && s1_reg.step && op.valid && op.step) |-> (addr != s1_addr_reg))
        else $error("consecutive steps hit the same delay entry");

    // a blocked step keeps its address and operand
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_reg.valid && !s1_adv) |=> (s1_reg.valid && $stable(s1_addr_reg) && $stable(cur)))
        else $error("stalled update stage lost its operand");

    // every completed step lands in the output register
    a_step_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_adv && s1_reg.step) |=> m_valid_reg)
        else $error("completed step produced no sample");

    // the memory is written only when the update stage moves on
    a_write_on_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_now |-> (s1_reg.valid && take))
        else $error("delay line written without advancing");

endmodule

// ===== hw/rtl/plucked_string_synth.sv =====
// Plucked-string voice: one input item per cycle, damped delay line in a block memory.
// Each accepted item issues one delay-line read into the update stage register; that stage
// averages the read entry with the previous step's result, scales it by the damping gain,
// writes it back and registers the output sample. The block takes one item every cycle;
// the single read-modify-write of the delay memory per item sets that rate, and it pauses
// only while the output register holds a sample that the sink has not taken. A load request
// writes one excitation entry and restarts the note; every entry of the active length must
// be loaded before stepping. Change the registers only while no request is in flight.
module plucked_string_synth
    import psynth_pkg::*;
#(
    parameter int MAX_DELAY = MAX_DELAY_DEF,
    parameter int MAX_NOTE  = MAX_NOTE_DEF
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [9:0] entry_index, [17:10] excitation, [23:18] zero
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] sample
    output logic        m_tlast
);

    localparam int AW = $clog2(MAX_DELAY);

    cfg_t                cfg;
    op_t                 op;
    logic [AW-1:0]       addr;
    logic [SAMPLE_W-1:0] load_data;
    logic                take, accept;

    assign s_tready = take;
    assign accept   = s_tvalid && take;

    psynth_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    psynth_issue #(
        .MAX_DELAY (MAX_DELAY),
        .MAX_NOTE  (MAX_NOTE)
    ) u_issue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .accept      (accept),
        .action      (s_tuser),
        .entry_index (s_tdata[9:0]),
        .excitation  (s_tdata[17:10]),
        .op          (op),
        .addr        (addr),
        .load_data   (load_data)
    );

    psynth_loop #(
        .MAX_DELAY (MAX_DELAY)
    ) u_loop (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .op        (op),
        .addr      (addr),
        .load_data (load_data),
        .take      (take),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
